[sv/esub_pkg.sv]
// ----------------------------------------------------------------------------
// esub_pkg
// Types and constants shared by the event subscription table modules.
// ----------------------------------------------------------------------------
package esub_pkg;

  localparam int unsigned POOL_NODES  = 64;
  localparam int unsigned EVENT_SLOTS = 32;
  localparam int unsigned SCAN_LEN    = (POOL_NODES > EVENT_SLOTS) ? POOL_NODES : EVENT_SLOTS;
  localparam int unsigned NODE_W      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned SLOT_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int unsigned SCAN_W      = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

  localparam logic [1:0] ACT_SUBSCRIBE   = 2'd0;
  localparam logic [1:0] ACT_UNSUBSCRIBE = 2'd1;
  localparam logic [1:0] ACT_LIST        = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POOL_FULL  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] event_type;
    logic [31:0] task_id;
  } in_t;

  typedef struct packed {
    logic [31:0] subscriber;
    logic [1:0]  status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic       load_req;
    logic       scan;
    logic       set_cur_head;
    logic       rd;
    logic       adv;
    logic       new_event;
    logic       append_tail;
    logic       alloc;
    logic       unlink;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_sub;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       scan_last;
    logic       slot_found;
    logic       free_slot_found;
    logic       free_node_found;
    logic       task_match;
    logic       cur_end;
  } stat_t;

endpackage

[sv/esub_datapath.sv]
// ----------------------------------------------------------------------------
// esub_datapath
// Event table, node pool memories, scan and walk registers, result register.
// ----------------------------------------------------------------------------
module esub_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  esub_pkg::in_t  req_i,
  input  esub_pkg::cmd_t cmd_i,
  output esub_pkg::stat_t stat_o,
  output logic           result_valid_o,
  output esub_pkg::out_t result_o
);
  import esub_pkg::*;

  logic [EVENT_SLOTS-1:0] ev_valid_q;
  logic [31:0]            ev_key_q  [EVENT_SLOTS];
  logic [NODE_W-1:0]      ev_head_q [EVENT_SLOTS];
  logic [POOL_NODES-1:0]  node_used_q;
  logic [POOL_NODES-1:0]  node_end_q;
  logic [31:0]            node_task_mem [POOL_NODES];
  logic [NODE_W-1:0]      node_next_mem [POOL_NODES];

  in_t               req_q;
  logic [SCAN_W-1:0] cnt_q;
  logic              slot_found_q, free_slot_found_q, free_node_found_q;
  logic [SLOT_W-1:0] slot_q, free_slot_q;
  logic [NODE_W-1:0] free_node_q;
  logic [NODE_W-1:0] cur_q, prev_q;
  logic              head_flag_q;
  logic [31:0]       task_rd_q;
  logic [NODE_W-1:0] next_rd_q;
  logic              valid_q;
  out_t              out_q;

  logic              in_slots, in_pool;
  logic [SLOT_W-1:0] cnt_slot;
  logic [NODE_W-1:0] cnt_node;
  logic              nx_we;
  logic [NODE_W-1:0] nx_waddr, nx_wdata;

  assign in_slots = {1'b0, cnt_q} < (SCAN_W+1)'(EVENT_SLOTS);
  assign in_pool  = {1'b0, cnt_q} < (SCAN_W+1)'(POOL_NODES);
  assign cnt_slot = cnt_q[SLOT_W-1:0];
  assign cnt_node = cnt_q[NODE_W-1:0];

  assign nx_we    = cmd_i.append_tail || (cmd_i.unlink && !head_flag_q);
  assign nx_waddr = cmd_i.append_tail ? cur_q : prev_q;
  assign nx_wdata = cmd_i.append_tail ? free_node_q : next_rd_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q        <= '0;
      node_used_q       <= '0;
      node_end_q        <= '1;
      valid_q           <= 1'b0;
      slot_found_q      <= 1'b0;
      free_slot_found_q <= 1'b0;
      free_node_found_q <= 1'b0;
      cnt_q             <= '0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load_req) begin
        cnt_q             <= '0;
        slot_found_q      <= 1'b0;
        free_slot_found_q <= 1'b0;
        free_node_found_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        cnt_q <= cnt_q + 1'b1;
        if (in_slots) begin
          if (!slot_found_q && ev_valid_q[cnt_slot] && ev_key_q[cnt_slot] == req_q.event_type)
            slot_found_q <= 1'b1;
          if (!free_slot_found_q && !ev_valid_q[cnt_slot])
            free_slot_found_q <= 1'b1;
        end
        if (in_pool && !free_node_found_q && !node_used_q[cnt_node])
          free_node_found_q <= 1'b1;
      end
      if (cmd_i.new_event) ev_valid_q[free_slot_q] <= 1'b1;
      if (cmd_i.append_tail) node_end_q[cur_q] <= 1'b0;
      if (cmd_i.alloc) begin
        node_used_q[free_node_q] <= 1'b1;
        node_end_q[free_node_q]  <= 1'b1;
      end
      if (cmd_i.unlink) begin
        if (head_flag_q) begin
          if (node_end_q[cur_q]) ev_valid_q[slot_q] <= 1'b0;
        end else begin
          node_end_q[prev_q] <= node_end_q[cur_q];
        end
        node_used_q[cur_q] <= 1'b0;
        node_end_q[cur_q]  <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.scan) begin
      if (in_slots) begin
        if (!slot_found_q && ev_valid_q[cnt_slot] && ev_key_q[cnt_slot] == req_q.event_type)
          slot_q <= cnt_slot;
        if (!free_slot_found_q && !ev_valid_q[cnt_slot])
          free_slot_q <= cnt_slot;
      end
      if (in_pool && !free_node_found_q && !node_used_q[cnt_node])
        free_node_q <= cnt_node;
    end
    if (cmd_i.new_event) begin
      ev_key_q[free_slot_q]  <= req_q.event_type;
      ev_head_q[free_slot_q] <= free_node_q;
    end
    if (cmd_i.unlink && head_flag_q && !node_end_q[cur_q])
      ev_head_q[slot_q] <= next_rd_q;
    if (cmd_i.set_cur_head) begin
      cur_q       <= ev_head_q[slot_q];
      head_flag_q <= 1'b1;
    end
    if (cmd_i.adv) begin
      prev_q      <= cur_q;
      cur_q       <= next_rd_q;
      head_flag_q <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_q.subscriber <= cmd_i.emit_sub ? task_rd_q : 32'd0;
      out_q.status     <= cmd_i.emit_status;
      out_q.last       <= cmd_i.emit_last;
    end
  end

  // node pool memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) node_task_mem[free_node_q] <= req_q.task_id;
    if (cmd_i.rd) task_rd_q <= node_task_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) node_next_mem[nx_waddr] <= nx_wdata;
    if (cmd_i.rd) next_rd_q <= node_next_mem[cur_q];
  end

  assign stat_o.action          = req_q.action;
  assign stat_o.scan_last       = (cnt_q == SCAN_W'(SCAN_LEN - 1));
  assign stat_o.slot_found      = slot_found_q;
  assign stat_o.free_slot_found = free_slot_found_q;
  assign stat_o.free_node_found = free_node_found_q;
  assign stat_o.task_match      = (task_rd_q == req_q.task_id);
  assign stat_o.cur_end         = node_end_q[cur_q];

  assign result_valid_o = valid_q;
  assign result_o       = out_q;

endmodule

[sv/esub_ctrl.sv]
// ----------------------------------------------------------------------------
// esub_ctrl
// Request sequencer: table scan, decision, list walk and result issue.
// ----------------------------------------------------------------------------
module esub_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  esub_pkg::stat_t stat_i,
  output esub_pkg::cmd_t  cmd_o
);
  import esub_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_RD     = 3'd3;
  localparam logic [2:0] S_SUB    = 3'd4;
  localparam logic [2:0] S_UNS    = 3'd5;
  localparam logic [2:0] S_LIST   = 3'd6;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        case (stat_i.action)
          ACT_SUBSCRIBE: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            if (!stat_i.free_node_found) begin
              cmd_o.emit_status = ST_POOL_FULL;
            end else if (!stat_i.slot_found) begin
              if (!stat_i.free_slot_found) begin
                cmd_o.emit_status = ST_TABLE_FULL;
              end else begin
                cmd_o.new_event   = 1'b1;
                cmd_o.alloc       = 1'b1;
                cmd_o.emit_status = ST_OK;
              end
            end else begin
              cmd_o.emit         = 1'b0;
              cmd_o.set_cur_head = 1'b1;
              state_d            = S_RD;
            end
          end
          ACT_UNSUBSCRIBE, ACT_LIST: begin
            if (!stat_i.slot_found) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = ST_NOT_FOUND;
            end else begin
              cmd_o.set_cur_head = 1'b1;
              state_d            = S_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        case (stat_i.action)
          ACT_SUBSCRIBE:   state_d = S_SUB;
          ACT_UNSUBSCRIBE: state_d = S_UNS;
          default:         state_d = S_LIST;
        endcase
      end
      S_SUB: begin
        if (stat_i.cur_end) begin
          cmd_o.append_tail = 1'b1;
          cmd_o.alloc       = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      S_UNS: begin
        if (stat_i.task_match) begin
          cmd_o.unlink      = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else if (stat_i.cur_end) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_NOT_FOUND;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      S_LIST: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_sub    = 1'b1;
        cmd_o.emit_status = ST_OK;
        cmd_o.emit_last   = stat_i.cur_end;
        if (stat_i.cur_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/event_subscription_table.sv]
// ----------------------------------------------------------------------------
// event_subscription_table
// Event types with ordered subscriber lists built from a shared node pool.
// ----------------------------------------------------------------------------
// A request is taken on req_i when start is high and busy is low. Every
// request first scans the event table and the node pool, one entry a cycle,
// finding the matching slot, a free slot and the lowest free node. Subscribe
// then walks to the tail of the list if the event exists, unsubscribe walks
// until the task matches and list walks the whole list, each visiting a node
// in a read state (S_RD) and then a step state, because every step waits on
// the node memory read. Results appear on result_o for exactly one cycle with
// result_valid_o high; result_o.last marks the final result of a request.
// busy stays high until the final transfer is issued. Results cannot be
// stalled. After reset all event slots and nodes are free.
// ----------------------------------------------------------------------------
module event_subscription_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  esub_pkg::in_t  req_i,
  output logic           result_valid_o,
  output esub_pkg::out_t result_o
);
  import esub_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  esub_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  esub_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
